@@ rtl/tccd_pkg.sv @@
// Shared types and character codes for the tool changer command decoder.
package tccd_pkg;

  typedef enum logic [1:0] {
    MotorStop = 2'd0,
    MotorCw   = 2'd1,
    MotorCcw  = 2'd2
  } motor_e;

  typedef enum logic [1:0] {
    NumSkip  = 2'd0,
    NumSign  = 2'd1,
    NumDigit = 2'd2,
    NumDone  = 2'd3
  } num_phase_e;

  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChVt    = 8'd11;
  localparam logic [7:0] ChFf    = 8'd12;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChComma = 8'd44;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;
  localparam logic [7:0] ChLowA  = 8'd97;
  localparam logic [7:0] ChLowZ  = 8'd122;
  localparam logic [7:0] CaseGap = 8'd32;

  localparam logic [7:0] CmdA = 8'd65;
  localparam logic [7:0] CmdB = 8'd66;
  localparam logic [7:0] CmdC = 8'd67;
  localparam logic [7:0] CmdH = 8'd72;
  localparam logic [7:0] CmdJ = 8'd74;
  localparam logic [7:0] CmdK = 8'd75;
  localparam logic [7:0] CmdL = 8'd76;
  localparam logic [7:0] CmdO = 8'd79;
  localparam logic [7:0] CmdP = 8'd80;
  localparam logic [7:0] CmdQ = 8'd81;
  localparam logic [7:0] CmdU = 8'd85;

  localparam logic [7:0] EchoReset  = 8'd48;
  localparam logic [7:0] DelayReset = 8'd1;
  localparam logic [7:0] OnReset    = 8'd5;

  typedef struct packed {
    logic       line_end;
    logic       pump_start;
    logic [7:0] on_time_setting;
    logic [7:0] delay_setting;
    logic [7:0] last_command_code;
    logic [1:0] motor_mode;
    logic       dir_level;
    logic       step_level;
    logic       umbrella_level;
    logic       tool_clamp_level;
    logic       spindle_orient_level;
  } result_t;

endpackage

@@ rtl/tool_changer_command_decoder_unit.sv @@
// Tool changer command decoder: byte stream in, actuator levels and settings out.
// Each input transaction passes through the input register and then the result register.
// Throughput: one byte per cycle unless the output stalls; one byte can wait in the input register.
// Reset: asynchronous, active low; clears the line buffer, orient high, clamp, umbrella
// and motor off, echo '0', delay 1, on time 5.
module tool_changer_command_decoder_unit #(
  parameter int LINE_CHARS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [7:0] rx_byte
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [0] spindle_orient_level, [1] tool_clamp_level, [2] umbrella_level,
  // [3] step_level, [4] dir_level, [6:5] motor_mode, [14:7] last_command_code,
  // [22:15] delay_setting, [30:23] on_time_setting, [31] pump_start
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  localparam int CntW = $clog2(LINE_CHARS);
  localparam logic [CntW-1:0] CntMax = CntW'(LINE_CHARS - 1);

  // Input register stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  // Result register stage
  logic                 out_valid_q;
  tccd_pkg::result_t    out_q, out_d;

  logic advance;

  // Line assembly state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ended_q, ended_d;
  logic [1:0]      fidx_q, fidx_d;
  logic            inside_q, inside_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [1:0]      phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [7:0]      acc_q, acc_d;
  logic [8:0]      pend_delay_q, pend_delay_d;  // [8] present, [7:0] value
  logic [8:0]      pend_on_q, pend_on_d;

  // Persistent outputs
  logic       orient_q, orient_d;
  logic       clamp_q, clamp_d;
  logic       umbrella_q, umbrella_d;
  logic [1:0] motor_q, motor_d;
  logic [7:0] echo_q, echo_d;
  logic [7:0] delay_q, delay_d;
  logic [7:0] on_q, on_d;
  logic       pump;
  logic       line_end;

  // Advance the input stage when the result register is free or being drained.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Per-byte update: fold case, then either run the line or absorb one character while the line buffer has room.
  always_comb begin : update
    logic [7:0] c;
    logic       digit;
    logic       blank;
    logic       skip_num;
    logic [1:0] fi;
    logic [1:0] ph;
    logic       ng;
    logic [7:0] ac;
    logic [7:0] v;

    cnt_d        = cnt_q;
    ended_d      = ended_q;
    fidx_d       = fidx_q;
    inside_d     = inside_q;
    cmd_d        = cmd_q;
    phase_d      = phase_q;
    neg_d        = neg_q;
    acc_d        = acc_q;
    pend_delay_d = pend_delay_q;
    pend_on_d    = pend_on_q;
    orient_d     = orient_q;
    clamp_d      = clamp_q;
    umbrella_d   = umbrella_q;
    motor_d      = motor_q;
    echo_d       = echo_q;
    delay_d      = delay_q;
    on_d         = on_q;
    pump         = 1'b0;
    line_end     = 1'b0;
    skip_num     = 1'b0;
    fi           = fidx_q;
    ph           = phase_q;
    ng           = neg_q;
    ac           = acc_q;
    v            = 8'd0;

    c = in_byte_q;
    if (c inside {[tccd_pkg::ChLowA:tccd_pkg::ChLowZ]}) begin
      c = c - tccd_pkg::CaseGap;
    end
    digit = c inside {[tccd_pkg::ChZero:tccd_pkg::ChNine]};
    blank = c inside {tccd_pkg::ChSpace, tccd_pkg::ChTab, tccd_pkg::ChVt,
                      tccd_pkg::ChFf, tccd_pkg::ChCr};

    if (c == tccd_pkg::ChLf) begin
      line_end = 1'b1;
      // Run the command only if at least one field was seen.
      if (fidx_q != 2'd0) begin
        case (cmd_q)
          tccd_pkg::CmdH: begin echo_d = cmd_q; orient_d = 1'b0; end
          tccd_pkg::CmdJ: begin echo_d = cmd_q; orient_d = 1'b1; end
          tccd_pkg::CmdP: begin echo_d = cmd_q; umbrella_d = 1'b1; end
          tccd_pkg::CmdU: begin echo_d = cmd_q; clamp_d = 1'b1; end
          tccd_pkg::CmdK: begin echo_d = cmd_q; umbrella_d = 1'b0; end
          tccd_pkg::CmdL: begin echo_d = cmd_q; clamp_d = 1'b0; end
          tccd_pkg::CmdA: begin echo_d = cmd_q; motor_d = tccd_pkg::MotorCw; end
          tccd_pkg::CmdB: begin echo_d = cmd_q; motor_d = tccd_pkg::MotorCcw; end
          tccd_pkg::CmdC: begin echo_d = cmd_q; motor_d = tccd_pkg::MotorStop; end
          tccd_pkg::CmdO: begin
            // Load both settings only when both number fields were present.
            if (pend_delay_q[8] && pend_on_q[8]) begin
              echo_d  = cmd_q;
              delay_d = pend_delay_q[7:0];
              on_d    = pend_on_q[7:0];
            end
          end
          tccd_pkg::CmdQ: begin echo_d = cmd_q; pump = 1'b1; end
          default: ;
        endcase
      end
      cnt_d        = '0;
      ended_d      = 1'b0;
      fidx_d       = 2'd0;
      inside_d     = 1'b0;
      cmd_d        = 8'd0;
      phase_d      = tccd_pkg::NumSkip;
      neg_d        = 1'b0;
      acc_d        = 8'd0;
      pend_delay_d = 9'd0;
      pend_on_d    = 9'd0;
    end else if (cnt_q < CntMax) begin
      cnt_d = cnt_q + 1'b1;
      if (!ended_q) begin
        if (c == tccd_pkg::ChNul) begin
          ended_d = 1'b1;
        end else if (c == tccd_pkg::ChComma) begin
          inside_d = 1'b0;
        end else begin
          if (!inside_q) begin
            inside_d = 1'b1;
            if (fidx_q == 2'd0) begin
              cmd_d    = c;
              fi       = 2'd1;
              skip_num = 1'b1;
            end else if (fidx_q != 2'd3) begin
              fi = fidx_q + 2'd1;
              ph = tccd_pkg::NumSkip;
              ng = 1'b0;
              ac = 8'd0;
            end else begin
              ph = tccd_pkg::NumDone;
            end
          end
          // Number fields: atoi-style parse, wrapping to 8 bits.
          if (!skip_num && fi[1] && ph != tccd_pkg::NumDone) begin
            case (ph)
              tccd_pkg::NumSkip: begin
                if (blank) begin
                  ph = tccd_pkg::NumSkip;
                end else if (c == tccd_pkg::ChPlus) begin
                  ph = tccd_pkg::NumSign;
                end else if (c == tccd_pkg::ChMinus) begin
                  ph = tccd_pkg::NumSign;
                  ng = 1'b1;
                end else if (digit) begin
                  ac = c - tccd_pkg::ChZero;
                  ph = tccd_pkg::NumDigit;
                end else begin
                  ph = tccd_pkg::NumDone;
                end
              end
              tccd_pkg::NumSign, tccd_pkg::NumDigit: begin
                if (digit) begin
                  ac = (ac << 3) + (ac << 1) + (c - tccd_pkg::ChZero);
                  ph = tccd_pkg::NumDigit;
                end else begin
                  ph = tccd_pkg::NumDone;
                end
              end
              default: ;
            endcase
            v = ng ? (~ac + 8'd1) : ac;
            if (fi == 2'd2) begin
              pend_delay_d = {1'b1, v};
            end else begin
              pend_on_d = {1'b1, v};
            end
          end
          fidx_d  = fi;
          phase_d = ph;
          neg_d   = ng;
          acc_d   = ac;
        end
      end
    end

    out_d.spindle_orient_level = orient_d;
    out_d.tool_clamp_level     = clamp_d;
    out_d.umbrella_level       = umbrella_d;
    out_d.step_level           = (motor_d == tccd_pkg::MotorCw);
    out_d.dir_level            = (motor_d == tccd_pkg::MotorCcw);
    out_d.motor_mode           = motor_d;
    out_d.last_command_code    = echo_d;
    out_d.delay_setting        = delay_d;
    out_d.on_time_setting      = on_d;
    out_d.pump_start           = pump;
    out_d.line_end             = line_end;
  end

  // Commit state on each processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      ended_q      <= 1'b0;
      fidx_q       <= 2'd0;
      inside_q     <= 1'b0;
      cmd_q        <= 8'd0;
      phase_q      <= tccd_pkg::NumSkip;
      neg_q        <= 1'b0;
      acc_q        <= 8'd0;
      pend_delay_q <= 9'd0;
      pend_on_q    <= 9'd0;
      orient_q     <= 1'b1;
      clamp_q      <= 1'b0;
      umbrella_q   <= 1'b0;
      motor_q      <= tccd_pkg::MotorStop;
      echo_q       <= tccd_pkg::EchoReset;
      delay_q      <= tccd_pkg::DelayReset;
      on_q         <= tccd_pkg::OnReset;
    end else if (advance) begin
      cnt_q        <= cnt_d;
      ended_q      <= ended_d;
      fidx_q       <= fidx_d;
      inside_q     <= inside_d;
      cmd_q        <= cmd_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      acc_q        <= acc_d;
      pend_delay_q <= pend_delay_d;
      pend_on_q    <= pend_on_d;
      orient_q     <= orient_d;
      clamp_q      <= clamp_d;
      umbrella_q   <= umbrella_d;
      motor_q      <= motor_d;
      echo_q       <= echo_d;
      delay_q      <= delay_d;
      on_q         <= on_d;
    end
  end

  // Result register: hold until the downstream side takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q[31:0];
  assign m_axis_tlast_o  = out_q.line_end;

  // A pump pulse only comes with the byte that ends a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[31] |-> m_axis_tlast_o)
    else $error("pump_start without line_end");

  // Step and direction levels are never driven together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[3] && m_axis_tdata_o[4]))
    else $error("step and dir both high");

  // The motor state never takes the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    motor_q != 2'd3)
    else $error("motor state out of range");

  // The line buffer is empty right after a line-ending byte is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && line_end |=> (cnt_q == '0) && (fidx_q == 2'd0) && !pend_delay_q[8])
    else $error("line state not cleared at line end");

endmodule
